// ===== design/smst_pkg.sv =====
package smst_pkg;

    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;
    localparam int OUT_W   = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_COUNT  = 2'd2,
        KIND_DEDUP  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic               cmp;
        logic               ins;
        logic               del;
        logic [VALUE_W-1:0] key;
    } t_cell_cmd;

endpackage

// ===== design/smst_req_if.sv =====
interface smst_req_if import smst_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

// ===== design/smst_rsp_if.sv =====
interface smst_rsp_if import smst_pkg::*;;
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [OUT_W-1:0] match_count;
    logic [OUT_W-1:0] size;

    modport source (output valid, output accepted, output match_count, output size,
                    input ready);
    modport sink (input valid, input accepted, input match_count, input size,
                  output ready);
endinterface

// ===== design/smst_cell.sv =====
module smst_cell import smst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_cmd          i_cmd,
    input  logic [VALUE_W-1:0] i_left_value,
    input  logic               i_left_valid,
    input  logic               i_left_le,
    input  logic [VALUE_W-1:0] i_right_value,
    input  logic               i_right_valid,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_valid,
    output logic               o_le,
    output logic               o_lt
);

    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_valid, n_valid;
    logic               r_le, n_le;
    logic               r_lt, n_lt;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        n_le    = r_le;
        n_lt    = r_lt;
        if (i_cmd.cmp) begin
            n_le = r_valid && ($signed(r_value) <= $signed(i_cmd.key));
            n_lt = r_valid && ($signed(r_value) < $signed(i_cmd.key));
        end else if (i_cmd.ins) begin
            if (!r_le) begin
                n_value = i_left_le ? i_cmd.key : i_left_value;
                n_valid = r_valid | i_left_valid;
            end
        end else if (i_cmd.del) begin
            if (!r_lt) begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_le    <= 1'b0;
            r_lt    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_le    <= n_le;
            r_lt    <= n_lt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_le    = r_le;
    assign o_lt    = r_lt;

endmodule

// ===== design/sorted_multiset_table_unit.sv =====
// Sorted multiset table: keeps up to CAPACITY signed 32-bit values in ascending order in a
// row of cells, one value per cell. A request carries an operation (add, remove one, count,
// remove duplicates) and a value, and yields one response with the accepted flag, the number
// of copies present before the operation and the size after it. Requests are served one at a
// time. Each request passes through the accept step, a compare pass in which every cell checks
// its value against the key, and an execute step that does one insert or delete shift through
// the row where the operation needs one and loads the response register. Remove duplicates
// adds one more compare and delete-shift pair for each copy beyond the first. The input is
// taken again as soon as the previous request reaches the response register, even if that
// response has not been taken; a request then waits in its execute step while the response
// register stays full.
module sorted_multiset_table_unit import smst_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smst_req_if.sink   i_req,
    smst_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0]  w_value [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_le;
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY:0]   w_le_pad;
    logic [CAPACITY:0]   w_lt_pad;
    logic [CW-1:0]       w_le_cnt;
    logic [CW-1:0]       w_lt_cnt;
    logic [CW-1:0]       w_match;
    logic                w_full;
    logic                w_can_out;
    t_cell_cmd           w_cmd;

    t_state             r_state, n_state;
    t_kind              r_kind;
    logic [VALUE_W-1:0] r_key;
    logic               r_first, n_first;
    logic [CW-1:0]      r_match, n_match;
    logic [CW-1:0]      r_count, n_count;

    logic               r_out_valid;
    logic               r_out_acc, n_out_acc;
    logic [OUT_W-1:0]   r_out_match, n_out_match;
    logic [OUT_W-1:0]   r_out_size;
    logic               w_load;

    // row of compare and shift cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] w_lv, w_rv;
        logic               w_lvalid, w_lle, w_rvalid;
        if (i == 0) begin : g_first
            assign w_lv     = r_key;
            assign w_lvalid = 1'b1;
            assign w_lle    = 1'b1;
        end else begin : g_mid
            assign w_lv     = w_value[i-1];
            assign w_lvalid = w_valid[i-1];
            assign w_lle    = w_le[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_rv     = w_value[i];
            assign w_rvalid = 1'b0;
        end else begin : g_inner
            assign w_rv     = w_value[i+1];
            assign w_rvalid = w_valid[i+1];
        end
        smst_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_value  (w_lv),
            .i_left_valid  (w_lvalid),
            .i_left_le     (w_lle),
            .i_right_value (w_rv),
            .i_right_valid (w_rvalid),
            .o_value       (w_value[i]),
            .o_valid       (w_valid[i]),
            .o_le          (w_le[i]),
            .o_lt          (w_lt[i])
        );
    end

    // compare flags form prefixes: their edge position is the count
    assign w_le_pad = {1'b0, w_le};
    assign w_lt_pad = {1'b0, w_lt};

    always_comb begin
        w_le_cnt = '0;
        w_lt_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_le_pad[i] && !w_le_pad[i+1]) begin
                w_le_cnt = w_le_cnt | CW'(i + 1);
            end
            if (w_lt_pad[i] && !w_lt_pad[i+1]) begin
                w_lt_cnt = w_lt_cnt | CW'(i + 1);
            end
        end
    end

    assign w_match   = w_le_cnt - w_lt_cnt;
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_can_out = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_match     = r_match;
        n_count     = r_count;
        n_out_acc   = 1'b0;
        n_out_match = 5'(w_match);
        w_load      = 1'b0;
        w_cmd.cmp   = 1'b0;
        w_cmd.ins   = 1'b0;
        w_cmd.del   = 1'b0;
        w_cmd.key   = r_key;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_CMP;
                    n_first = 1'b1;
                end
            end
            ST_CMP: begin
                w_cmd.cmp = 1'b1;
                n_state   = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_kind == KIND_DEDUP && w_match > CW'(1)) begin
                    // drop one extra copy and compare again
                    w_cmd.del = 1'b1;
                    n_count   = r_count - CW'(1);
                    n_first   = 1'b0;
                    n_state   = ST_CMP;
                    if (r_first) begin
                        n_match = w_match;
                    end
                end else if (w_can_out) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                    case (r_kind)
                        KIND_ADD: begin
                            n_out_acc = !w_full;
                            w_cmd.ins = !w_full;
                            if (!w_full) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        KIND_REMOVE: begin
                            n_out_acc = (w_match != '0);
                            w_cmd.del = (w_match != '0);
                            if (w_match != '0) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        KIND_COUNT: begin
                            n_out_acc = (w_match != '0);
                        end
                        KIND_DEDUP: begin
                            n_out_acc = 1'b1;
                            if (!r_first) begin
                                n_out_match = 5'(r_match);
                            end
                        end
                        default: begin
                            n_out_acc = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_first <= n_first;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
        if (r_state == ST_IDLE && i_req.valid) begin
            r_kind <= t_kind'(i_req.kind);
            r_key  <= i_req.value;
        end
        if (w_load) begin
            r_out_acc   <= n_out_acc;
            r_out_match <= n_out_match;
            r_out_size  <= 5'(n_count);
        end
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.accepted    = r_out_acc;
    assign o_rsp.match_count = r_out_match;
    assign o_rsp.size        = r_out_size;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + CAPACITY'(1)) & w_valid) == '0)
        else $error("valid cells not packed at the front");

    a_req_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == ST_CMP))
        else $error("request not followed by compare pass");

    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_state) == ST_EXEC))
        else $error("response loaded outside execute step");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import smst_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_OPS   = 1150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int POOL_SIZE    = 6;

    typedef struct {
        t_kind              kind;
        logic signed [31:0] value;
        bit                 wait_drain;
    } table_op_t;

    typedef struct {
        logic             accepted;
        logic [OUT_W-1:0] match_count;
        logic [OUT_W-1:0] size;
    } table_answer_t;

    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_QUARTER,
        SINK_BURSTY
    } t_sink_mode;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_op_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smst_req_if req_if ();
    smst_rsp_if rsp_if ();

    sorted_multiset_table_unit #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    table_op_t          ops_to_send[$];
    table_answer_t      pending_answers[$];
    logic signed [31:0] table_entries[$];
    logic signed [31:0] value_pool[POOL_SIZE];

    int         errors     = 0;
    int         idle_count = 0;
    bit         req_taken  = 1'b0;
    int         burst_left = 1;
    int         gap_left   = 0;
    int         mode_left  = 0;
    int         stall_left = 0;
    int         sink_tick  = 0;
    t_sink_mode sink_mode  = SINK_ALWAYS;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mirror of the table: applies one request and returns its answer
    function automatic table_answer_t apply_to_table(t_kind kind, logic signed [31:0] value);
        table_answer_t answer;
        int copies;
        int pos;
        copies = 0;
        pos    = -1;
        foreach (table_entries[idx]) begin
            if (table_entries[idx] == value) begin
                copies++;
                if (pos < 0) pos = idx;
            end
        end
        answer.accepted = 1'b0;
        case (kind)
            KIND_ADD: begin
                if (table_entries.size() < TABLE_DEPTH) begin
                    pos = 0;
                    while (pos < table_entries.size() && table_entries[pos] <= value) pos++;
                    table_entries.insert(pos, value);
                    answer.accepted = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (copies > 0) begin
                    table_entries.delete(pos);
                    answer.accepted = 1'b1;
                end
            end
            KIND_COUNT: begin
                answer.accepted = (copies > 0);
            end
            default: begin
                for (int n = 1; n < copies; n++) table_entries.delete(pos + 1);
                answer.accepted = 1'b1;
            end
        endcase
        answer.match_count = copies[OUT_W-1:0];
        answer.size        = OUT_W'(table_entries.size());
        return answer;
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                     actual);
        end
    endfunction

    task automatic push_op(t_kind kind, logic signed [31:0] value, bit wait_drain = 1'b0);
        table_op_t op;
        op.kind       = kind;
        op.value      = value;
        op.wait_drain = wait_drain;
        ops_to_send.push_back(op);
    endtask

    // request side: bursts with random gaps
    always @(negedge i_clk) begin
        table_op_t op;
        logic      send_now;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            req_taken = 1'b0;
            send_now  = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (ops_to_send.size() > 0 &&
                         (!ops_to_send[0].wait_drain || pending_answers.size() == 0)) begin
                op       = ops_to_send.pop_front();
                send_now = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
            req_if.valid <= send_now;
            if (send_now) begin
                req_if.kind  <= op.kind;
                req_if.value <= op.value;
            end
        end
    end

    // response side: stall pattern switches mode every so often
    always @(negedge i_clk) begin
        logic ready_next;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            sink_tick++;
            case (sink_mode)
                SINK_ALWAYS:  ready_next = 1'b1;
                SINK_COIN:    ready_next = 1'($urandom_range(0, 1));
                SINK_QUARTER: ready_next = (sink_tick % 4 == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        ready_next = 1'b0;
                    end else begin
                        ready_next = 1'b1;
                        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 25);
                    end
                end
            endcase
            rsp_if.ready <= ready_next;
        end
    end

    always @(posedge i_clk) begin
        table_answer_t expected;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pending_answers.push_back(apply_to_table(t_kind'(req_if.kind), req_if.value));
                req_taken = 1'b1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_answers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                             $time, rsp_if.accepted, rsp_if.match_count, rsp_if.size);
                end else begin
                    expected = pending_answers.pop_front();
                    check_field("accepted", expected.accepted, rsp_if.accepted);
                    check_field("match_count", expected.match_count, rsp_if.match_count);
                    check_field("size", expected.size, rsp_if.size);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_count = 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("[sorted_multiset_table_unit] ERROR");
            $finish;
        end else begin
            idle_count++;
        end
    end

    initial begin
        int                 r;
        int                 mix_left;
        t_op_mix            mix;
        t_kind              kind;
        logic signed [31:0] value;

        req_if.valid = 1'b0;
        req_if.kind  = KIND_ADD;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        i_rst_n      = 1'b0;

        // empty table, extremes, copies, full table and long dedup
        push_op(KIND_COUNT, 0);
        push_op(KIND_REMOVE, 5);
        push_op(KIND_DEDUP, 7);
        push_op(KIND_ADD, 32'sh8000_0000);
        push_op(KIND_ADD, 32'sh7fff_ffff);
        push_op(KIND_ADD, 0);
        push_op(KIND_ADD, -1);
        push_op(KIND_ADD, 0);
        push_op(KIND_ADD, 0);
        push_op(KIND_COUNT, 0);
        push_op(KIND_DEDUP, 0);
        push_op(KIND_DEDUP, -1);
        for (int n = 0; n < 12; n++) push_op(KIND_ADD, 42);
        push_op(KIND_ADD, 42);
        push_op(KIND_COUNT, 32'sh8000_0000);
        push_op(KIND_DEDUP, 42, 1'b1);
        push_op(KIND_REMOVE, 32'sh7fff_ffff);
        push_op(KIND_REMOVE, 32'sh7fff_ffff);

        mix_left = 0;
        mix      = MIX_EVEN;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (mix_left == 0) begin
                mix      = t_op_mix'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 80);
                foreach (value_pool[p]) begin
                    case ($urandom_range(0, 4))
                        0:       value_pool[p] = $urandom_range(0, 8) - 4;
                        1:       value_pool[p] = 32'sh8000_0000 + $urandom_range(0, 3);
                        2:       value_pool[p] = 32'sh7fff_ffff - $urandom_range(0, 3);
                        default: value_pool[p] = $urandom;
                    endcase
                end
            end
            mix_left--;
            r = $urandom_range(0, 99);
            case (mix)
                MIX_GROW:   kind = (r < 70) ? KIND_ADD : t_kind'(r % 4);
                MIX_SHRINK: kind = (r < 15) ? KIND_ADD : (r < 55) ? KIND_REMOVE :
                                   (r < 80) ? KIND_DEDUP : KIND_COUNT;
                default:    kind = t_kind'(r % 4);
            endcase
            if ($urandom_range(0, 9) < 8) value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else value = $urandom;
            push_op(kind, value, (i % 300 == 0));
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (ops_to_send.size() > 0 || req_if.valid) @(posedge i_clk);
        while (pending_answers.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("[sorted_multiset_table_unit] OK");
        end else begin
            $display("[sorted_multiset_table_unit] ERROR");
        end
        $finish;
    end

endmodule
